// ===== src/tcprq_pkg.sv =====
// Package for the two-class priority ring queue: record type, codes and defaults.
`timescale 1ns / 1ps

package tcprq_pkg;

    // Default ring depth, shared by both classes
    localparam int DEPTH_DEF = 8;

    // Fixed field widths
    localparam int KEY_W  = 32;
    localparam int USED_W = 4;

    // Operation codes carried on the kind input
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // One stored record: key and flag
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             flag;
    } t_record;

endpackage

// ===== src/two_class_priority_ring_queue_core.sv =====
// Top level: two-class priority ring queue held in two synchronous record memories.
`timescale 1ns / 1ps

// Two circular queues of records, urgent and normal, each DEPTH deep, each in its own
// single-port-write / single-port-read memory with a registered read. An enqueue beat
// writes the record into the chosen ring unless it is full; a dequeue beat takes the
// head record of the urgent ring if it holds anything, else of the normal ring. Every
// accepted beat gives exactly one result, strobed on o_done for one cycle, in the cycle
// after the beat is taken: the head slot is read through the registered memory read. A new
// beat is taken every cycle (busy stays low), so the block sustains one item per cycle.
// The receiver cannot stall: results must be captured in the cycle o_done is high.
// o_urgent_used and o_normal_used show the ring counts after the item, masked to 4 bits.
// Record fields read zero on an enqueue and on a failed dequeue.
module two_class_priority_ring_queue_core #(
    parameter int DEPTH = tcprq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_kind,
    input  logic signed [tcprq_pkg::KEY_W-1:0] i_key,
    input  logic                              i_record_flag,
    input  logic                              i_urgent,
    output logic                              o_done,
    output logic                              o_ok,
    output logic signed [tcprq_pkg::KEY_W-1:0] o_out_key,
    output logic                              o_out_flag,
    output logic [tcprq_pkg::USED_W-1:0]      o_urgent_used,
    output logic [tcprq_pkg::USED_W-1:0]      o_normal_used
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // Record memories
    tcprq_pkg::t_record u_mem [DEPTH];
    tcprq_pkg::t_record n_mem [DEPTH];

    // Ring pointers and counts
    logic [IW-1:0] r_u_head, n_u_head;
    logic [IW-1:0] r_n_head, n_n_head;
    logic [CW-1:0] r_u_fill, n_u_fill;
    logic [CW-1:0] r_n_fill, n_n_fill;

    // Result control
    logic r_done, r_ok, r_pop, r_pop_u;

    // Registered read data of both head slots
    tcprq_pkg::t_record r_u_rd, r_n_rd;

    logic               acc;
    logic               is_enq;
    logic               push_u, push_n, pop_u, pop_n;
    logic [IW-1:0]      u_tail, n_tail;
    logic [SW-1:0]      u_sum, n_sum;
    logic [IW-1:0]      u_head_inc, n_head_inc;
    tcprq_pkg::t_record wr_rec;

    assign busy   = 1'b0;
    assign acc    = start && !busy;
    assign is_enq = (i_kind == tcprq_pkg::KIND_ENQ);
    assign wr_rec = '{key: i_key, flag: i_record_flag};

    // Decide which ring moves
    always_comb begin
        push_u = acc && is_enq && i_urgent && (r_u_fill != FULL_CNT);
        push_n = acc && is_enq && !i_urgent && (r_n_fill != FULL_CNT);
        pop_u  = acc && !is_enq && (r_u_fill != '0);
        pop_n  = acc && !is_enq && (r_u_fill == '0) && (r_n_fill != '0);
    end

    // Tail slots: (head + fill) wrapped once
    always_comb begin
        u_sum = SW'(r_u_head) + SW'(r_u_fill);
        n_sum = SW'(r_n_head) + SW'(r_n_fill);
        if (u_sum >= DEPTH_S) begin
            u_sum = u_sum - DEPTH_S;
        end
        if (n_sum >= DEPTH_S) begin
            n_sum = n_sum - DEPTH_S;
        end
        u_tail = u_sum[IW-1:0];
        n_tail = n_sum[IW-1:0];
    end

    // Advance heads with wrap
    always_comb begin
        u_head_inc = (SW'(r_u_head) == DEPTH_S - SW'(1)) ? '0 : r_u_head + IW'(1);
        n_head_inc = (SW'(r_n_head) == DEPTH_S - SW'(1)) ? '0 : r_n_head + IW'(1);
    end

    // Next pointer and count values
    always_comb begin
        n_u_head = pop_u ? u_head_inc : r_u_head;
        n_n_head = pop_n ? n_head_inc : r_n_head;
        n_u_fill = r_u_fill;
        n_n_fill = r_n_fill;
        if (push_u) begin
            n_u_fill = r_u_fill + CW'(1);
        end else if (pop_u) begin
            n_u_fill = r_u_fill - CW'(1);
        end
        if (push_n) begin
            n_n_fill = r_n_fill + CW'(1);
        end else if (pop_n) begin
            n_n_fill = r_n_fill - CW'(1);
        end
    end

    // Memory write ports and registered head reads
    always_ff @(posedge i_clk) begin
        if (push_u) begin
            u_mem[u_tail] <= wr_rec;
        end
        if (push_n) begin
            n_mem[n_tail] <= wr_rec;
        end
        r_u_rd <= u_mem[r_u_head];
        r_n_rd <= n_mem[r_n_head];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_head <= '0;
            r_n_head <= '0;
            r_u_fill <= '0;
            r_n_fill <= '0;
            r_done   <= 1'b0;
            r_ok     <= 1'b0;
            r_pop    <= 1'b0;
            r_pop_u  <= 1'b0;
        end else begin
            r_u_head <= n_u_head;
            r_n_head <= n_n_head;
            r_u_fill <= n_u_fill;
            r_n_fill <= n_n_fill;
            r_done   <= acc;
            r_ok     <= push_u || push_n || pop_u || pop_n;
            r_pop    <= pop_u || pop_n;
            r_pop_u  <= pop_u;
        end
    end

    // Drive the result beat
    always_comb begin
        o_done        = r_done;
        o_ok          = r_ok;
        o_out_key     = '0;
        o_out_flag    = 1'b0;
        if (r_pop) begin
            o_out_key  = r_pop_u ? r_u_rd.key  : r_n_rd.key;
            o_out_flag = r_pop_u ? r_u_rd.flag : r_n_rd.flag;
        end
        o_urgent_used = tcprq_pkg::USED_W'(r_u_fill);
        o_normal_used = tcprq_pkg::USED_W'(r_n_fill);
    end

endmodule
